@@ hw/rtl/tte_pkg.sv @@
package tte_pkg;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_TAP  = 2'd1;
    localparam logic [1:0] OP_SET  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_TEMPO = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TEMPO = 4'd1;

    localparam logic [15:0] MIN_TEMPO_RST = 16'd100;
    localparam logic [15:0] MAX_TEMPO_RST = 16'd51200;
    localparam logic [15:0] TEMPO_RST     = 16'd12000;

    // Hundredths of a beat per minute in one beat per second.
    localparam longint unsigned HBPM_PER_HZ = 64'd6000;

    // The phase step is found in sixteenths and then rounded.
    localparam int ROUND_BITS = 4;

    localparam int OUT_DATA_W = 88;

    // Serial unit widths: 64-bit quotient register, 32-bit divisor.
    localparam int QUOT_W = 64;
    localparam int DSR_W  = 32;

    typedef enum logic [1:0] {
        UOP_MEAN,
        UOP_SCALE,
        UOP_TEMPO,
        UOP_STEP
    } uop_t;

    typedef struct packed {
        logic accept;
        logic tick;
        logic tap;
        logic set;
        logic unit_start;
        uop_t unit_op;
        logic mean_wr;
        logic scale_wr;
        logic tempo_wr;
        logic step_wr;
        logic out_load;
        logic updated;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       tap_first;
        logic       unit_done;
    } dp_status_t;

    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    // The lower clamp is applied first, so the upper clamp wins when they cross.
    function automatic logic [15:0] clamp_tempo(input logic [15:0] t,
                                                input logic [15:0] lo,
                                                input logic [15:0] hi);
        logic [15:0] v;
        v = (t < lo) ? lo : t;
        v = (v > hi) ? hi : v;
        return v;
    endfunction

endpackage

@@ hw/rtl/tte_mdu.sv @@
module tte_mdu
    import tte_pkg::*;
#(
    parameter logic [31:0] STEP_Q = 32'd89478,
    parameter logic [31:0] STEP_R = 32'd372736,
    parameter logic [15:0] STEP_M = 16'd31806,
    parameter logic [31:0] STEP_D = 32'd768000
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              long_op,
    input  logic [31:0]       dividend_hi,
    input  logic [DSR_W-1:0]  divisor,
    input  logic [15:0]       mplier,
    output logic [QUOT_W-1:0] quotient,
    output logic              done
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_DIV  = 3'd1;
    localparam logic [2:0] PH_PROD = 3'd2;
    localparam logic [2:0] PH_BACK = 3'd3;
    localparam logic [2:0] PH_FIX  = 3'd4;

    localparam int CNT_W = $clog2(32 + 1);
    localparam logic [CNT_W-1:0] SHORT_STEPS = CNT_W'(32);

    logic [2:0]        phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [QUOT_W-1:0] q_reg, q_next;
    logic [DSR_W-1:0]  rem_reg, rem_next;
    logic [15:0]       mpl_reg, mpl_next;
    logic [DSR_W-1:0]  dsr_reg, dsr_next;
    logic              done_reg, done_next;
    logic [47:0]       base_reg, base_next;
    logic [47:0]       num_reg, num_next;
    logic [15:0]       est_reg, est_next;
    logic [47:0]       back_reg, back_next;

    logic [DSR_W:0]    trial;
    logic [DSR_W:0]    diff;
    logic              fits;
    logic [47:0]       base_prod;
    logic [47:0]       num_prod;
    logic [31:0]       est_prod;
    logic [47:0]       back_prod;
    logic [47:0]       resid;
    logic              corr;

    // One restoring step: bring down the next dividend bit and try the divisor.
    // A zero divisor always fits, so its quotient saturates to all ones.
    assign trial = {rem_reg, q_reg[QUOT_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    // The phase step in sixteenths is tempo*Q plus floor(tempo*R/D). The
    // second term is estimated with a 16-bit reciprocal, which can come out
    // one low, and the remainder check adds that one back.
    assign base_prod = {32'b0, mpl_reg} * {16'b0, STEP_Q};
    assign num_prod  = {32'b0, mpl_reg} * {16'b0, STEP_R};
    assign est_prod  = {16'b0, mpl_reg} * {16'b0, STEP_M};
    assign back_prod = {32'b0, est_reg} * {16'b0, STEP_D};
    assign resid     = num_reg - back_reg;
    assign corr      = resid >= {16'b0, STEP_D};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        mpl_next   = mpl_reg;
        dsr_next   = dsr_reg;
        base_next  = base_reg;
        num_next   = num_reg;
        est_next   = est_reg;
        back_next  = back_reg;
        done_next  = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    dsr_next = divisor;
                    rem_next = '0;
                    if (long_op)
                    begin
                        mpl_next   = mplier;
                        phase_next = PH_PROD;
                    end
                    else
                    begin
                        q_next     = {dividend_hi, {(QUOT_W-32){1'b0}}};
                        cnt_next   = SHORT_STEPS;
                        phase_next = PH_DIV;
                    end
                end
            end
            PH_DIV:
            begin
                rem_next = fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
                q_next   = {q_reg[QUOT_W-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
            end
            PH_PROD:
            begin
                base_next  = base_prod;
                num_next   = num_prod;
                est_next   = est_prod[31:16];
                phase_next = PH_BACK;
            end
            PH_BACK:
            begin
                back_next  = back_prod;
                phase_next = PH_FIX;
            end
            PH_FIX:
            begin
                q_next     = QUOT_W'(base_reg) + QUOT_W'(est_reg) + QUOT_W'(corr);
                phase_next = PH_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        mpl_reg  <= mpl_next;
        dsr_reg  <= dsr_next;
        base_reg <= base_next;
        num_reg  <= num_next;
        est_reg  <= est_next;
        back_reg <= back_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

@@ hw/rtl/tte_datapath.sv @@
module tte_datapath
    import tte_pkg::*;
#(
    parameter int unsigned     TICK_RATE        = 128,
    parameter longint unsigned PHASE_FULL_SCALE = 64'd4294967296,
    parameter int unsigned     INTERVAL_SCALE   = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic [1:0]             s_tuser,
    input  logic [15:0]            s_tdata,
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    localparam int SCALED_W = 16 + $clog2(INTERVAL_SCALE + 1);
    localparam logic [SCALED_W-1:0] SCALE_K = SCALED_W'(INTERVAL_SCALE);
    localparam logic [DSR_W-1:0] SCALE_DSR = DSR_W'(INTERVAL_SCALE);
    localparam logic [15:0] TIMEOUT_TICKS = 16'(4 * TICK_RATE);
    localparam longint unsigned STEP_NUM = PHASE_FULL_SCALE * (64'd1 << ROUND_BITS);
    localparam longint unsigned STEP_DEN = HBPM_PER_HZ * TICK_RATE;
    localparam logic [31:0] STEP_QUO = 32'(STEP_NUM / STEP_DEN);
    localparam logic [31:0] STEP_REM = 32'(STEP_NUM % STEP_DEN);
    localparam logic [15:0] STEP_RCP = 16'(((STEP_NUM % STEP_DEN) * 64'd65536) / STEP_DEN);
    localparam logic [31:0] STEP_DIV = 32'(STEP_DEN);
    localparam logic [31:0] TEMPO_NUM =
        32'(HBPM_PER_HZ * TICK_RATE * INTERVAL_SCALE);
    localparam logic [31:0] STEP_RST = 32'((64'd2 * PHASE_FULL_SCALE) / TICK_RATE);

    logic [1:0]  op_reg, op_next;
    logic [15:0] req_reg, req_next;
    logic [15:0] min_reg, min_next;
    logic [15:0] max_reg, max_next;
    logic [15:0] tick_reg, tick_next;
    logic [15:0] tap_reg, tap_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] mean_reg, mean_next;
    logic [15:0] mean_div_reg, mean_div_next;
    logic [15:0] last_reg, last_next;
    logic        metro_reg, metro_next;
    logic        active_reg, active_next;
    logic [15:0] tempo_reg, tempo_next;
    logic [31:0] step_reg, step_next;
    logic [OUT_DATA_W-1:0] out_reg, out_next;

    logic                unit_long;
    logic [31:0]         unit_dividend;
    logic [DSR_W-1:0]    unit_divisor;
    logic [QUOT_W-1:0]   unit_quot;
    logic                unit_done;

    logic [15:0]         tick_inc;
    logic [15:0]         tap_inc;
    logic [15:0]         metro_div;
    logic [SCALED_W-1:0] scaled_tick;
    logic [SCALED_W-1:0] scaled_eff;
    logic [33:0]         mean_x3_half;
    logic                outlier;
    logic [15:0]         tick_eff;
    logic [32:0]         sum;

    always_comb
    begin
        unit_long     = 1'b0;
        unit_dividend = '0;
        unit_divisor  = '0;
        case (cmd.unit_op)
            UOP_MEAN:
            begin
                unit_dividend = total_reg;
                unit_divisor  = DSR_W'(tap_reg - 16'd1);
            end
            UOP_SCALE:
            begin
                // Dividing the total by the interval count times the scale
                // gives the same floor as dividing the mean by the scale.
                unit_dividend = total_reg;
                unit_divisor  = {16'b0, tap_reg - 16'd1} * SCALE_DSR;
            end
            UOP_TEMPO:
            begin
                unit_dividend = TEMPO_NUM;
                unit_divisor  = mean_reg;
            end
            UOP_STEP:
            begin
                unit_long = 1'b1;
            end
            default:
            begin
                unit_long = 1'b0;
            end
        endcase
    end

    tte_mdu #(
        .STEP_Q (STEP_QUO),
        .STEP_R (STEP_REM),
        .STEP_M (STEP_RCP),
        .STEP_D (STEP_DIV)
    ) u_mdu (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmd.unit_start),
        .long_op     (unit_long),
        .dividend_hi (unit_dividend),
        .divisor     (unit_divisor),
        .mplier      (tempo_reg),
        .quotient    (unit_quot),
        .done        (unit_done)
    );

    assign tick_inc  = (tick_reg != 16'hFFFF) ? tick_reg + 16'd1 : tick_reg;
    assign tap_inc   = (tap_reg != 16'hFFFF) ? tap_reg + 16'd1 : tap_reg;
    assign metro_div = (mean_div_reg == 16'd0) ? 16'd1 : mean_div_reg;

    // From the fourth tap on, an interval longer than 3/2 of the mean is
    // replaced by the mean itself.
    assign scaled_tick  = SCALED_W'(tick_reg) * SCALE_K;
    assign mean_x3_half = ({2'b00, mean_reg} + {1'b0, mean_reg, 1'b0}) >> 1;
    assign outlier      = (34'(scaled_tick) > mean_x3_half) && (tap_inc > 16'd3);
    assign tick_eff     = outlier ? mean_div_reg : tick_reg;
    assign scaled_eff   = SCALED_W'(tick_eff) * SCALE_K;
    assign sum          = {1'b0, total_reg} + 33'(scaled_eff);

    always_comb
    begin
        op_next       = op_reg;
        req_next      = req_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        tick_next     = tick_reg;
        tap_next      = tap_reg;
        total_next    = total_reg;
        mean_next     = mean_reg;
        mean_div_next = mean_div_reg;
        last_next     = last_reg;
        metro_next    = metro_reg;
        active_next   = active_reg;
        tempo_next    = tempo_reg;
        step_next     = step_reg;
        out_next      = out_reg;

        if (cfg_valid)
        begin
            if (cfg_index == REG_MIN_TEMPO)
            begin
                min_next = cfg_data;
            end
            else if (cfg_index == REG_MAX_TEMPO)
            begin
                max_next = cfg_data;
            end
        end

        if (cmd.accept)
        begin
            op_next  = s_tuser;
            req_next = s_tdata;
        end

        // Ticks only count while a measurement runs.
        if (cmd.tick && active_reg)
        begin
            tick_next  = tick_inc;
            metro_next = {tick_inc, 1'b0} >= {1'b0, metro_div};
            if (tick_inc > TIMEOUT_TICKS)
            begin
                tap_next    = '0;
                active_next = 1'b0;
                metro_next  = 1'b0;
            end
        end

        if (cmd.tap)
        begin
            tap_next = tap_inc;
            if (tap_reg == 16'd0)
            begin
                tick_next   = '0;
                total_next  = '0;
                active_next = 1'b1;
            end
            else
            begin
                total_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                last_next  = tick_eff;
                tick_next  = '0;
            end
        end

        if (cmd.set)
        begin
            tempo_next = clamp_tempo(req_reg, min_reg, max_reg);
        end

        if (cmd.mean_wr)
        begin
            mean_next = unit_quot[31:0];
        end

        if (cmd.scale_wr)
        begin
            mean_div_next = sat16(unit_quot[31:0]);
        end

        if (cmd.tempo_wr)
        begin
            tempo_next = clamp_tempo(sat16(unit_quot[31:0]), min_reg, max_reg);
        end

        // Round the sixteenths up when the dropped part is half or more.
        if (cmd.step_wr)
        begin
            step_next = unit_quot[ROUND_BITS+31:ROUND_BITS]
                      + 32'(unit_quot[ROUND_BITS-1]);
        end

        if (cmd.out_load)
        begin
            out_next = {5'b0, last_reg, sat16(mean_reg), step_reg, tempo_reg,
                        cmd.updated, active_reg, metro_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      <= MIN_TEMPO_RST;
            max_reg      <= MAX_TEMPO_RST;
            tick_reg     <= '0;
            tap_reg      <= '0;
            total_reg    <= '0;
            mean_reg     <= '0;
            mean_div_reg <= '0;
            last_reg     <= '0;
            metro_reg    <= 1'b0;
            active_reg   <= 1'b0;
            tempo_reg    <= TEMPO_RST;
            step_reg     <= STEP_RST;
        end
        else
        begin
            min_reg      <= min_next;
            max_reg      <= max_next;
            tick_reg     <= tick_next;
            tap_reg      <= tap_next;
            total_reg    <= total_next;
            mean_reg     <= mean_next;
            mean_div_reg <= mean_div_next;
            last_reg     <= last_next;
            metro_reg    <= metro_next;
            active_reg   <= active_next;
            tempo_reg    <= tempo_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        req_reg <= req_next;
        out_reg <= out_next;
    end

    assign status.op        = op_reg;
    assign status.tap_first = (tap_reg == 16'd0);
    assign status.unit_done = unit_done;
    assign m_tdata          = out_reg;

endmodule

@@ hw/rtl/tte_ctrl.sv @@
module tte_ctrl
    import tte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DISPATCH   = 4'd1;
    localparam logic [3:0] S_MEAN_GO    = 4'd2;
    localparam logic [3:0] S_MEAN_WAIT  = 4'd3;
    localparam logic [3:0] S_SCALE_GO   = 4'd4;
    localparam logic [3:0] S_SCALE_WAIT = 4'd5;
    localparam logic [3:0] S_TEMPO_GO   = 4'd6;
    localparam logic [3:0] S_TEMPO_WAIT = 4'd7;
    localparam logic [3:0] S_STEP_GO    = 4'd8;
    localparam logic [3:0] S_STEP_WAIT  = 4'd9;
    localparam logic [3:0] S_RESULT     = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       upd_reg, upd_next;
    logic       valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        upd_next   = upd_reg;
        valid_next = valid_reg && !m_tready;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.op)
                    OP_TICK:
                    begin
                        cmd.tick   = 1'b1;
                        upd_next   = 1'b0;
                        state_next = S_RESULT;
                    end
                    OP_TAP:
                    begin
                        cmd.tap = 1'b1;
                        if (status.tap_first)
                        begin
                            upd_next   = 1'b0;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            upd_next   = 1'b1;
                            state_next = S_MEAN_GO;
                        end
                    end
                    OP_SET:
                    begin
                        cmd.set    = 1'b1;
                        upd_next   = 1'b1;
                        state_next = S_STEP_GO;
                    end
                    default:
                    begin
                        upd_next   = 1'b0;
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_MEAN_GO:
            begin
                cmd.unit_start = 1'b1;
                cmd.unit_op    = UOP_MEAN;
                state_next     = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                cmd.unit_op = UOP_MEAN;
                if (status.unit_done)
                begin
                    cmd.mean_wr = 1'b1;
                    state_next  = S_SCALE_GO;
                end
            end
            S_SCALE_GO:
            begin
                cmd.unit_start = 1'b1;
                cmd.unit_op    = UOP_SCALE;
                state_next     = S_SCALE_WAIT;
            end
            S_SCALE_WAIT:
            begin
                cmd.unit_op = UOP_SCALE;
                if (status.unit_done)
                begin
                    cmd.scale_wr = 1'b1;
                    state_next   = S_TEMPO_GO;
                end
            end
            S_TEMPO_GO:
            begin
                cmd.unit_start = 1'b1;
                cmd.unit_op    = UOP_TEMPO;
                state_next     = S_TEMPO_WAIT;
            end
            S_TEMPO_WAIT:
            begin
                cmd.unit_op = UOP_TEMPO;
                if (status.unit_done)
                begin
                    cmd.tempo_wr = 1'b1;
                    state_next   = S_STEP_GO;
                end
            end
            S_STEP_GO:
            begin
                cmd.unit_start = 1'b1;
                cmd.unit_op    = UOP_STEP;
                state_next     = S_STEP_WAIT;
            end
            S_STEP_WAIT:
            begin
                cmd.unit_op = UOP_STEP;
                if (status.unit_done)
                begin
                    cmd.step_wr = 1'b1;
                    state_next  = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // The output register takes the result once it is empty or
                // being drained in this cycle.
                if (!valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    cmd.updated  = upd_reg;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            upd_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            upd_reg   <= upd_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

endmodule

@@ hw/rtl/tap_tempo_estimator.sv @@
// Channel   Handshake            Contents
// s_        s_tvalid/s_tready    s_tuser item kind, s_tdata requested tempo
// m_        m_tvalid/m_tready    m_tdata flags, tempo, phase step, intervals
// cfg_      cfg_valid/cfg_ready  cfg_index register number, cfg_data value
//
// A tick, a first tap or an unused kind goes from dispatch straight to the result
// state; the next request is taken once the result is in the output register.
// A direct tempo setting goes from dispatch to the phase step. A closing tap
// first runs three 32-step serial divisions (mean, metronome divisor, tempo);
// both then compute the phase step, which comes from a reciprocal product and
// one correction, before the result state loads the result.
// Reset returns every control and state register but the held request and its
// kind to its initial value at once; there is no clearing pass.
// A new request is taken while the previous result still waits in the output
// register; a stalled output only holds the block before it loads the next result.
module tap_tempo_estimator
    import tte_pkg::*;
#(
    parameter int unsigned     TICK_RATE        = 128,
    parameter longint unsigned PHASE_FULL_SCALE = 64'd4294967296,
    parameter int unsigned     INTERVAL_SCALE   = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             s_tuser,   // [1:0] opcode
    input  logic [15:0]            s_tdata,   // [15:0] tempo_request
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] metronome, [1] measuring, [2] tempo_updated, [18:3] tempo_hbpm,
    // [50:19] phase_increment, [66:51] average_interval, [82:67] last_interval,
    // [87:83] zero
    output logic [OUT_DATA_W-1:0]  m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    tte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    tte_datapath #(
        .TICK_RATE        (TICK_RATE),
        .PHASE_FULL_SCALE (PHASE_FULL_SCALE),
        .INTERVAL_SCALE   (INTERVAL_SCALE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata)
    );

endmodule
